>>> sv/ctirq_pkg.sv
// Package for the console timer / interrupt / pad I/O block.
// Holds the bus item, result and state types, port and function codes.
// No dependencies.
package ctirq_pkg;

  // Prescaler divide ratio for the timer
  localparam int unsigned Prescale = 1024;
  localparam int unsigned PsW      = $clog2(Prescale);

  // Function codes
  localparam logic [1:0] FuncIdle  = 2'd0;
  localparam logic [1:0] FuncRead  = 2'd1;
  localparam logic [1:0] FuncWrite = 2'd2;

  // I/O page ports, address bits 12..10
  localparam logic [2:0] PortVideo  = 3'd0;
  localparam logic [2:0] PortColour = 3'd1;
  localparam logic [2:0] PortSound  = 3'd2;
  localparam logic [2:0] PortTimer  = 3'd3;
  localparam logic [2:0] PortPad    = 3'd4;
  localparam logic [2:0] PortIrq    = 3'd5;

  // Interrupt controller sub registers, address bits 1..0
  localparam logic [1:0] IrqSubMask    = 2'd2;
  localparam logic [1:0] IrqSubPending = 2'd3;

  // Pending bit positions
  localparam int unsigned BitVideo = 1;
  localparam int unsigned BitTimer = 2;

  localparam logic [7:0] OpenBus = 8'hFF;

  typedef struct packed {
    logic [1:0]  func;
    logic [12:0] io_address;
    logic [7:0]  write_data;
    logic        vdc_irq;
    logic [7:0]  pad_buttons;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       handled;
    logic       irq_active;
  } result_t;

  typedef struct packed {
    logic [6:0]     reload_value;
    logic [6:0]     count_value;
    logic [PsW-1:0] prescale_count;
    logic           timer_on;
    logic [2:0]     irq_mask;
    logic [2:0]     irq_flags;
    logic           pad_select;
    logic           pad_clear;
  } state_t;

endpackage

>>> sv/ctirq_if.sv
// Valid/ready channel interfaces for bus cycles in and results out.
// Depends on ctirq_pkg.
interface ctirq_req_if;
  import ctirq_pkg::*;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [12:0] io_address;
  logic [7:0]  write_data;
  logic        vdc_irq;
  logic [7:0]  pad_buttons;

  modport source (output valid, func, io_address, write_data, vdc_irq, pad_buttons,
                  input ready);
  modport sink   (input valid, func, io_address, write_data, vdc_irq, pad_buttons,
                  output ready);
endinterface

interface ctirq_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       handled;
  logic       irq_active;

  modport source (output valid, read_data, handled, irq_active, input ready);
  modport sink   (input valid, read_data, handled, irq_active, output ready);
endinterface

>>> sv/ctirq_step.sv
// Combinational next-state and result logic for one CPU bus cycle.
// Depends on ctirq_pkg.
module ctirq_step import ctirq_pkg::*; (
  input  state_t  st_i,
  input  item_t   item_i,
  output state_t  st_o,
  output result_t res_o
);

  logic [2:0] port;
  logic [1:0] sub;
  logic       access;
  logic       foreign;
  state_t     st_io;
  logic [7:0] rd;

  assign port    = item_i.io_address[12:10];
  assign sub     = item_i.io_address[1:0];
  assign foreign = (port == PortVideo) || (port == PortColour) || (port == PortSound);
  assign access  = ((item_i.func == FuncRead) || (item_i.func == FuncWrite)) && !foreign;

  // Video level, then the I/O access
  always_comb begin
    st_io = st_i;
    st_io.irq_flags[BitVideo] = item_i.vdc_irq;
    rd = '0;
    if (access && item_i.func == FuncRead) begin
      case (port)
        PortTimer: rd = {1'b0, st_i.count_value};
        PortPad:   rd = {4'h0, st_i.pad_select ? item_i.pad_buttons[7:4]
                                               : item_i.pad_buttons[3:0]};
        PortIrq: begin
          if (sub == IrqSubMask)         rd = {5'd0, st_i.irq_mask};
          else if (sub == IrqSubPending) rd = {5'd0, st_io.irq_flags};
          else                           rd = OpenBus;
        end
        default:   rd = OpenBus;
      endcase
    end else if (access && item_i.func == FuncWrite) begin
      case (port)
        PortTimer: begin
          if (!item_i.io_address[0]) begin
            st_io.reload_value = item_i.write_data[6:0];
          end else begin
            if (!st_i.timer_on && item_i.write_data[0]) begin
              st_io.count_value    = st_i.reload_value;
              st_io.prescale_count = '0;
            end
            st_io.timer_on = item_i.write_data[0];
          end
        end
        PortPad: begin
          st_io.pad_select = item_i.write_data[0];
          st_io.pad_clear  = item_i.write_data[1];
        end
        PortIrq: begin
          if (sub == IrqSubMask)         st_io.irq_mask = item_i.write_data[2:0];
          else if (sub == IrqSubPending) st_io.irq_flags[BitTimer] = 1'b0;
        end
        default: ;
      endcase
    end
  end

  // Timer tick after the request line is sampled
  always_comb begin
    st_o = st_io;
    if (st_io.timer_on) begin
      if (st_io.prescale_count >= PsW'(Prescale - 1)) begin
        st_o.prescale_count = '0;
        if (st_io.count_value == 7'd0) begin
          st_o.count_value         = st_io.reload_value;
          st_o.irq_flags[BitTimer] = 1'b1;
        end else begin
          st_o.count_value = st_io.count_value - 7'd1;
        end
      end else begin
        st_o.prescale_count = st_io.prescale_count + PsW'(1);
      end
    end
  end

  assign res_o.read_data  = rd;
  assign res_o.handled    = access;
  assign res_o.irq_active = |(st_io.irq_flags & ~st_io.irq_mask);

endmodule

>>> sv/console_timer_irq_pad_io_core.sv
// Top level of the console timer / interrupt / pad I/O block.
// Depends on ctirq_pkg, ctirq_req_if, ctirq_rsp_if and ctirq_step.
//
// Takes one CPU bus cycle per clock and returns one result per cycle unless
// the result side stalls: read data, a handled flag (0 for video, colour and
// sound ports and idle cycles) and the CPU interrupt request. Each transaction
// passes an input register, then the state update and decode logic into a
// result register, and a new transaction can be accepted every clock unless the
// result side stalls. Back pressure on the result side stalls the input
// register; block state advances only as a result is registered.
module console_timer_irq_pad_io_core import ctirq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  ctirq_req_if.sink   req_i,
  ctirq_rsp_if.source rsp_o
);

  item_t   item_q;
  logic    in_valid_q;
  result_t res_q;
  result_t res_d;
  logic    out_valid_q;
  state_t  st_q;
  state_t  st_d;
  logic    advance;

  assign advance     = in_valid_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready = !in_valid_q || advance;

  ctirq_step u_step (
    .st_i   (st_q),
    .item_i (item_q),
    .st_o   (st_d),
    .res_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      st_q        <= '0;
    end else begin
      if (req_i.ready) begin
        in_valid_q <= req_i.valid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        st_q        <= st_d;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.ready && req_i.valid) begin
      item_q.func        <= req_i.func;
      item_q.io_address  <= req_i.io_address;
      item_q.write_data  <= req_i.write_data;
      item_q.vdc_irq     <= req_i.vdc_irq;
      item_q.pad_buttons <= req_i.pad_buttons;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.read_data  = res_q.read_data;
  assign rsp_o.handled    = res_q.handled;
  assign rsp_o.irq_active = res_q.irq_active;

endmodule
